// ===== hdl/fmrb_pkg.sv =====
// ----------------------------------------------------------------------------
// fmrb_pkg
// Shared types and constants of the framed message ring buffer.
// ----------------------------------------------------------------------------
package fmrb_pkg;

  localparam int unsigned RingBytesDef = 4096;
  localparam int unsigned HeaderBytes  = 8;
  localparam int unsigned TailBytes    = 6;
  localparam logic [7:0]  TailMark     = 8'hAA;
  localparam int unsigned MinRing      = 16;

  localparam int unsigned SizeW   = 13;
  localparam int unsigned LenW    = 12;
  localparam int unsigned QueuedW = 9;
  localparam int unsigned PaddrW  = 3;

  localparam logic [PaddrW-1:0] RegRingSize = 3'd0;

  typedef enum logic {
    CmdPush = 1'b0,
    CmdPop  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StFull     = 3'd1,
    StEmpty    = 3'd2,
    StFrameErr = 3'd3,
    StTailErr  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SHdrWr,
    SDatWr,
    STailWr,
    SHdrRd,
    SHdrChk,
    SDatRd,
    SDatCap,
    STailRd,
    SEmit
  } state_e;

  typedef struct packed {
    logic [SizeW-1:0] capacity;
    logic [LenW-1:0]  length;
    logic [7:0]       data;
    cmd_e             cmd;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic [7:0]         read_byte;
    logic [LenW-1:0]    popped_length;
    logic               final_byte;
    logic [QueuedW-1:0] queued;
  } result_t;

endpackage

// ===== hdl/framed_message_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// framed_message_ring_buffer
// Byte ring of framed messages with push/pop streams and an APB size register.
// ----------------------------------------------------------------------------
// One beat in moves one message byte and gives one beat out. A push data byte
// passes SDatWr and SEmit, a pop data byte SDatRd, SDatCap and SEmit, and a
// dropped push, a zero-length push or an empty pop goes straight to SEmit.
// The first byte of a push adds the header write (SHdrWr), the first byte
// of a pop adds the header read and check (SHdrRd, SHdrChk; a frame error then
// answers without the data read), and the last byte adds the tail (STailWr for
// push, STailRd for pop). The sequencer moves header, data and tail bytes through
// the single byte-wide ring memory one byte at a time. A result beat stalled on
// m_axis_tready holds the sequencer only once the output register is also full. Writing ring_size empties the queue.
// The result register lets the next beat enter while a result waits.
module framed_message_ring_buffer
  import fmrb_pkg::*;
#(
  parameter int unsigned RING_BYTES = RingBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [39:0]       s_axis_tdata,  // data_byte, push_length, buffer_capacity
  input  logic              s_axis_tuser,  // command
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,  // read_byte, popped_length, queued_messages
  output logic [2:0]        m_axis_tuser,  // status
  output logic              m_axis_tlast   // final_byte
);

  logic [SizeW-1:0] size_q;
  logic cfg_wr, core_ready, res_valid, res_ready, out_valid_q;
  logic reg_sel;
  item_t item;
  result_t res, out_q;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PaddrW-1:2] == RegRingSize[PaddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? 32'(size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeW'(4096);
    end else if (cfg_wr) begin
      size_q <= pwdata[SizeW-1:0];
    end
  end

  assign item = '{capacity: s_axis_tdata[32:20], length: s_axis_tdata[19:8],
                  data: s_axis_tdata[7:0], cmd: cmd_e'(s_axis_tuser)};
  assign s_axis_tready = core_ready;

  fmrb_core #(.RING_BYTES(RING_BYTES)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_wr),
    .ring_size_i (size_q),
    .start_i     (s_axis_tvalid && core_ready),
    .item_i      (item),
    .ready_o     (core_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.final_byte;
  assign m_axis_tdata  = {3'b000, out_q.queued, out_q.popped_length, out_q.read_byte};

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("accepted a beat while busy");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == StEmpty) |-> (m_axis_tdata[28:20] == '0))
    else $error("empty status with messages queued");

  a_frame_err_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == StFrameErr) |-> (m_axis_tdata[28:20] == '0))
    else $error("frame error did not clear queue");
`endif

endmodule

// ===== hdl/fmrb_ram.sv =====
// ----------------------------------------------------------------------------
// fmrb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fmrb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/fmrb_core.sv =====
// ----------------------------------------------------------------------------
// fmrb_core
// Frame sequencer: header, data and tail accesses to the byte ring.
// ----------------------------------------------------------------------------
module fmrb_core
  import fmrb_pkg::*;
#(
  parameter int unsigned RING_BYTES = RingBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_wr_i,
  input  logic [SizeW-1:0] ring_size_i,
  input  logic             start_i,
  input  item_t            item_i,
  output logic             ready_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output result_t          res_o
);

  localparam int unsigned AW   = $clog2(RING_BYTES);
  localparam int unsigned SW   = AW + 1;
  localparam int unsigned CmpW = (SW > SizeW + 4) ? SW : SizeW + 4;
  localparam int unsigned CntW = ($clog2(RING_BYTES / 15 + 1) > QueuedW) ?
                                 $clog2(RING_BYTES / 15 + 1) : QueuedW;

  state_e state_q, state_d;
  logic [AW-1:0] rp_q, rp_d, wp_q, wp_d, ptr_q, ptr_d;
  logic [AW-1:0] push_cur_q, push_cur_d, pop_cur_q, pop_cur_d;
  logic [CntW-1:0] count_q, count_d;
  logic [LenW-1:0] push_rem_q, push_rem_d, pop_rem_q, pop_rem_d, pop_len_q, pop_len_d;
  logic drop_q, drop_d, bad_q, bad_d;
  logic [3:0] cnt_q, cnt_d;
  logic [63:0] hdr_q, hdr_d;
  item_t item_q, item_d;
  status_e st_q, st_d;
  logic [7:0] rb_q, rb_d;
  logic [LenW-1:0] plen_q, plen_d;
  logic fin_q, fin_d;

  logic [SW-1:0] size;
  logic [SW-1:0] free_sp;
  logic [CmpW-1:0] need;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] wdata, rdata;
  logic [63:0] hdr_w;
  logic [31:0] hlen;
  logic hdr_err;

  function automatic logic [AW-1:0] inc(logic [AW-1:0] p, logic [SW-1:0] sz);
    logic [SW-1:0] s;
    s = {1'b0, p} + SW'(1);
    if (s >= sz) begin
      s = s - sz;
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    if (17'(ring_size_i) < 17'(MinRing)) begin
      size = SW'(MinRing);
    end else if (17'(ring_size_i) > 17'(RING_BYTES)) begin
      size = SW'(RING_BYTES);
    end else begin
      size = SW'(ring_size_i);
    end
  end

  always_comb begin
    if (rp_q < wp_q || (rp_q == wp_q && count_q == '0)) begin
      free_sp = size - (SW'(wp_q) - SW'(rp_q));
    end else if (rp_q > wp_q) begin
      free_sp = SW'(rp_q) - SW'(wp_q);
    end else begin
      free_sp = '0;
    end
  end

  assign need    = CmpW'(item_i.length) + CmpW'(HeaderBytes + TailBytes);
  assign hdr_w   = {32'(item_q.length), 32'(wp_q)};
  assign hlen    = hdr_q[63:32];
  assign hdr_err = (32'(item_q.capacity) < hlen) || (hdr_q[31:0] != 32'(rp_q)) ||
                   (hlen == '0) || (hlen > 32'hFFF);

  fmrb_ram #(.Width(8), .Depth(RING_BYTES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d    = state_q;
    rp_d       = rp_q;
    wp_d       = wp_q;
    ptr_d      = ptr_q;
    push_cur_d = push_cur_q;
    pop_cur_d  = pop_cur_q;
    count_d    = count_q;
    push_rem_d = push_rem_q;
    pop_rem_d  = pop_rem_q;
    pop_len_d  = pop_len_q;
    drop_d     = drop_q;
    bad_d      = bad_q;
    cnt_d      = cnt_q;
    hdr_d      = hdr_q;
    item_d     = item_q;
    st_d       = st_q;
    rb_d       = rb_q;
    plen_d     = plen_q;
    fin_d      = fin_q;
    we         = 1'b0;
    waddr      = ptr_q;
    wdata      = TailMark;
    raddr      = ptr_q;

    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          item_d = item_i;
          st_d   = StOk;
          rb_d   = '0;
          plen_d = '0;
          fin_d  = 1'b0;
          cnt_d  = '0;
          state_d = SEmit;
          if (item_i.cmd == CmdPush) begin
            if (push_rem_q == '0) begin
              if (item_i.length == '0) begin
                st_d  = StFull;
                fin_d = 1'b1;
              end else if (CmpW'(free_sp) < need) begin
                drop_d     = 1'b1;
                push_rem_d = item_i.length - LenW'(1);
                fin_d      = (item_i.length == LenW'(1));
                st_d       = StFull;
              end else begin
                drop_d     = 1'b0;
                push_rem_d = item_i.length;
                ptr_d      = wp_q;
                state_d    = SHdrWr;
              end
            end else if (drop_q) begin
              push_rem_d = push_rem_q - LenW'(1);
              fin_d      = (push_rem_q == LenW'(1));
              st_d       = StFull;
            end else begin
              state_d = SDatWr;
            end
          end else begin
            if (pop_rem_q == '0) begin
              if (count_q == '0 && rp_q == wp_q) begin
                st_d = StEmpty;
              end else begin
                ptr_d   = rp_q;
                state_d = SHdrRd;
              end
            end else begin
              state_d = SDatRd;
            end
          end
        end
      end
      SHdrWr: begin
        we    = 1'b1;
        wdata = hdr_w[8*cnt_q[2:0] +: 8];
        ptr_d = inc(ptr_q, size);
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(HeaderBytes - 1)) begin
          push_cur_d = inc(ptr_q, size);
          state_d    = SDatWr;
        end
      end
      SDatWr: begin
        we         = 1'b1;
        waddr      = push_cur_q;
        wdata      = item_q.data;
        push_cur_d = inc(push_cur_q, size);
        push_rem_d = push_rem_q - LenW'(1);
        if (push_rem_q == LenW'(1)) begin
          fin_d   = 1'b1;
          ptr_d   = inc(push_cur_q, size);
          cnt_d   = '0;
          state_d = STailWr;
        end else begin
          state_d = SEmit;
        end
      end
      STailWr: begin
        we    = 1'b1;
        ptr_d = inc(ptr_q, size);
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(TailBytes - 1)) begin
          wp_d    = inc(ptr_q, size);
          count_d = count_q + CntW'(1);
          state_d = SEmit;
        end
      end
      SHdrRd: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q < 4'(HeaderBytes)) begin
          ptr_d = inc(ptr_q, size);
        end
        if (cnt_q != '0) begin
          hdr_d[8*(3'(cnt_q - 4'd1)) +: 8] = rdata;
        end
        if (cnt_q == 4'(HeaderBytes)) begin
          state_d = SHdrChk;
        end
      end
      SHdrChk: begin
        if (hdr_err) begin
          rp_d      = '0;
          wp_d      = '0;
          count_d   = '0;
          pop_rem_d = '0;
          pop_cur_d = '0;
          pop_len_d = '0;
          if (push_rem_q != '0) begin
            drop_d = 1'b1;
          end
          st_d    = StFrameErr;
          state_d = SEmit;
        end else begin
          pop_len_d = hlen[LenW-1:0];
          pop_rem_d = hlen[LenW-1:0];
          pop_cur_d = ptr_q;
          state_d   = SDatRd;
        end
      end
      SDatRd: begin
        raddr     = pop_cur_q;
        pop_cur_d = inc(pop_cur_q, size);
        state_d   = SDatCap;
      end
      SDatCap: begin
        rb_d      = rdata;
        plen_d    = pop_len_q;
        pop_rem_d = pop_rem_q - LenW'(1);
        bad_d     = 1'b0;
        if (pop_rem_q == LenW'(1)) begin
          fin_d   = 1'b1;
          ptr_d   = pop_cur_q;
          cnt_d   = '0;
          state_d = STailRd;
        end else begin
          state_d = SEmit;
        end
      end
      STailRd: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q < 4'(TailBytes)) begin
          ptr_d = inc(ptr_q, size);
        end
        if (cnt_q != '0 && rdata != TailMark) begin
          bad_d = 1'b1;
        end
        if (cnt_q == 4'(TailBytes)) begin
          rp_d = ptr_q;
          if (count_q != '0) begin
            count_d = count_q - CntW'(1);
          end
          st_d    = (bad_q || rdata != TailMark) ? StTailErr : StOk;
          state_d = SEmit;
        end
      end
      SEmit: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      rp_q       <= '0;
      wp_q       <= '0;
      push_cur_q <= '0;
      pop_cur_q  <= '0;
      count_q    <= '0;
      push_rem_q <= '0;
      pop_rem_q  <= '0;
      pop_len_q  <= '0;
      drop_q     <= 1'b0;
    end else if (cfg_wr_i) begin
      state_q    <= SIdle;
      rp_q       <= '0;
      wp_q       <= '0;
      push_cur_q <= '0;
      pop_cur_q  <= '0;
      count_q    <= '0;
      push_rem_q <= '0;
      pop_rem_q  <= '0;
      pop_len_q  <= '0;
      drop_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      rp_q       <= rp_d;
      wp_q       <= wp_d;
      push_cur_q <= push_cur_d;
      pop_cur_q  <= pop_cur_d;
      count_q    <= count_d;
      push_rem_q <= push_rem_d;
      pop_rem_q  <= pop_rem_d;
      pop_len_q  <= pop_len_d;
      drop_q     <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    cnt_q  <= cnt_d;
    hdr_q  <= hdr_d;
    item_q <= item_d;
    bad_q  <= bad_d;
    st_q   <= st_d;
    rb_q   <= rb_d;
    plen_q <= plen_d;
    fin_q  <= fin_d;
  end

  assign ready_o     = (state_q == SIdle);
  assign res_valid_o = (state_q == SEmit);
  assign res_o       = '{status: st_q, read_byte: rb_q, popped_length: plen_q,
                         final_byte: fin_q, queued: count_q[QueuedW-1:0]};

endmodule

// ===== tb/fmrb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmrb_checker
// Watches the APB port and both streams of the framed message ring buffer.
// Every accepted input beat is run through a local model of the ring (frames,
// pointers, push and pop progress) to get the expected output beat. Output
// beats are compared field by field against the oldest expected beat.
// ----------------------------------------------------------------------------
module fmrb_checker
  import fmrb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [39:0]       s_axis_tdata,
  input  logic              s_axis_tuser,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [31:0]       m_axis_tdata,
  input  logic [2:0]        m_axis_tuser,
  input  logic              m_axis_tlast,
  output int                errors_o,
  output int                pending_o
);

  logic [7:0]  ring_mem [RingBytesDef];
  int unsigned ring_len;
  int unsigned rd_ptr, wr_ptr, msg_cnt;
  int unsigned push_left, push_at;
  bit          push_drop;
  int unsigned pop_left, pop_at, pop_len;
  result_t     expected_q [$];
  int          errs;

  function automatic int unsigned fwd(int unsigned p, int unsigned n);
    return (p + n) % ring_len;
  endfunction

  function automatic int unsigned free_bytes();
    if (rd_ptr < wr_ptr || (rd_ptr == wr_ptr && msg_cnt == 0))
      return ring_len - (wr_ptr - rd_ptr);
    if (rd_ptr > wr_ptr)
      return rd_ptr - wr_ptr;
    return 0;
  endfunction

  task automatic clear_queue();
    rd_ptr = 0;
    wr_ptr = 0;
    msg_cnt = 0;
    pop_left = 0;
    pop_at = 0;
    pop_len = 0;
  endtask

  task automatic apply_size(logic [SizeW-1:0] v);
    ring_len = v < MinRing ? MinRing : (v > RingBytesDef ? RingBytesDef : v);
    clear_queue();
    push_left = 0;
    push_at = 0;
    push_drop = 0;
  endtask

  task automatic predict(item_t it);
    result_t     r;
    int unsigned idx, len;
    bit          give_byte, bad;
    r = '0;
    r.status = StOk;
    give_byte = 0;
    if (it.cmd == CmdPush) begin
      if (push_left == 0 && it.length == 0) begin
        r.status = StFull;
        r.final_byte = 1'b1;
      end else begin
        if (push_left == 0) begin
          len = it.length;
          if (free_bytes() < len + HeaderBytes + TailBytes) begin
            push_drop = 1;
          end else begin
            push_drop = 0;
            for (int i = 0; i < 4; i++) begin
              ring_mem[fwd(wr_ptr, i)]     = 8'(wr_ptr >> (8 * i));
              ring_mem[fwd(wr_ptr, 4 + i)] = 8'(len >> (8 * i));
            end
            push_at = fwd(wr_ptr, HeaderBytes);
          end
          push_left = len;
        end
        if (!push_drop) begin
          ring_mem[push_at] = it.data;
          push_at = fwd(push_at, 1);
        end
        push_left--;
        if (push_left == 0) begin
          r.final_byte = 1'b1;
          if (!push_drop) begin
            for (int i = 0; i < TailBytes; i++) ring_mem[fwd(push_at, i)] = TailMark;
            wr_ptr = fwd(push_at, TailBytes);
            msg_cnt++;
          end
        end
        if (push_drop) r.status = StFull;
      end
    end else begin
      if (pop_left != 0) begin
        give_byte = 1;
      end else if (msg_cnt == 0 && rd_ptr == wr_ptr) begin
        r.status = StEmpty;
      end else begin
        idx = 0;
        len = 0;
        for (int i = 0; i < 4; i++) begin
          idx |= int'(ring_mem[fwd(rd_ptr, i)]) << (8 * i);
          len |= int'(ring_mem[fwd(rd_ptr, 4 + i)]) << (8 * i);
        end
        if (it.capacity < len || idx != rd_ptr || len == 0 || len > 4095) begin
          clear_queue();
          if (push_left != 0) push_drop = 1;
          r.status = StFrameErr;
        end else begin
          pop_len = len;
          pop_left = len;
          pop_at = fwd(rd_ptr, HeaderBytes);
          give_byte = 1;
        end
      end
      if (give_byte) begin
        r.read_byte = ring_mem[pop_at];
        r.popped_length = LenW'(pop_len);
        pop_at = fwd(pop_at, 1);
        pop_left--;
        if (pop_left == 0) begin
          bad = 0;
          r.final_byte = 1'b1;
          for (int i = 0; i < TailBytes; i++)
            if (ring_mem[fwd(pop_at, i)] != TailMark) bad = 1;
          rd_ptr = fwd(pop_at, TailBytes);
          if (msg_cnt > 0) msg_cnt--;
          if (bad) r.status = StTailErr;
        end
      end
    end
    r.queued = QueuedW'(msg_cnt);
    expected_q.push_back(r);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    item_t   it;
    result_t want;
    if (!rst_ni) begin
      foreach (ring_mem[i]) ring_mem[i] = '0;
      apply_size(SizeW'(RingBytesDef));
      expected_q.delete();
      errs = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == RegRingSize)
        apply_size(pwdata[SizeW-1:0]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("output beat with no expected result");
          errs++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.status, m_axis_tuser);
          check_field("read_byte", want.read_byte, m_axis_tdata[7:0]);
          check_field("popped_length", want.popped_length, m_axis_tdata[19:8]);
          check_field("final_byte", want.final_byte, m_axis_tlast);
          check_field("queued_messages", want.queued, m_axis_tdata[28:20]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it.cmd      = cmd_e'(s_axis_tuser);
        it.data     = s_axis_tdata[7:0];
        it.length   = s_axis_tdata[19:8];
        it.capacity = s_axis_tdata[32:20];
        predict(it);
      end
      errors_o <= errs;
      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== tb/framed_message_ring_buffer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_message_ring_buffer_tb
// Drives push and pop byte streams into the framed message ring buffer under
// several ring sizes and idle/stall mixes; the checker predicts and compares.
// ----------------------------------------------------------------------------
module framed_message_ring_buffer_tb;
  import fmrb_pkg::*;

  localparam int WatchdogLimit = 5000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [39:0]       s_axis_tdata = '0;   // data_byte, push_length, buffer_capacity
  logic              s_axis_tuser = 1'b0; // command
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;        // read_byte, popped_length, queued_messages
  logic [2:0]        m_axis_tuser;        // status
  logic              m_axis_tlast;        // final_byte

  int errors, pending;
  int idle_pct = 0, stall_pct = 0, quiet = 0;

  // shaping state: committed frame lengths as the sender sees them
  int unsigned ring_sz = RingBytesDef, used = 0;
  int unsigned frames [$];
  int unsigned push_left = 0, pop_left = 0;
  int unsigned cur_push_len = 0;
  bit          push_ok = 0;

  always #5 clk_i = ~clk_i;

  framed_message_ring_buffer dut (.*);

  fmrb_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i)
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || psel) begin
      quiet <= 0;
    end else if (quiet >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send(cmd_e cmd, logic [7:0] data, logic [LenW-1:0] len,
                      logic [SizeW-1:0] cap);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'b0, cap, len, data};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_ring(logic [SizeW-1:0] v);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= RegRingSize;
    pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
    ring_sz = v < MinRing ? MinRing : (v > RingBytesDef ? RingBytesDef : v);
    used = 0;
    frames.delete();
    push_left = 0;
    pop_left = 0;
  endtask

  // one push byte; when no message is open, starts one of length force_len (random when 0)
  task automatic push_byte(int unsigned force_len);
    int unsigned lim, len;
    if (push_left == 0) begin
      lim = (ring_sz > 74) ? 60 : ring_sz - 14;
      if (force_len != 0) len = force_len;
      else if ($urandom_range(14) == 0) len = $urandom_range(1, lim + 20);
      else len = $urandom_range(1, lim);
      push_ok = (ring_sz - used) >= len + 14;
      push_left = len;
      cur_push_len = len;
      send(CmdPush, 8'($urandom), 12'(len), 13'($urandom));
    end else begin
      send(CmdPush, 8'($urandom), 12'($urandom), 13'($urandom));
    end
    push_left--;
    if (push_left == 0 && push_ok) begin
      frames.push_back(cur_push_len);
      used += cur_push_len + 14;
    end
  endtask

  task automatic pop_byte(bit allow_bad);
    int unsigned len;
    if (pop_left == 0) begin
      if (frames.size() == 0) begin
        send(CmdPop, 8'($urandom), 12'($urandom), 13'($urandom));
        return;
      end
      len = frames[0];
      if (allow_bad && $urandom_range(19) == 0) begin
        send(CmdPop, 8'($urandom), 12'($urandom), 13'($urandom_range(0, len - 1)));
        frames.delete();
        used = 0;
        push_ok = 0;
        return;
      end
      send(CmdPop, 8'($urandom), 12'($urandom), 13'($urandom_range(len, 8191)));
      pop_left = len;
    end else begin
      send(CmdPop, 8'($urandom), 12'($urandom), 13'($urandom));
    end
    pop_left--;
    if (pop_left == 0) begin
      used -= frames[0] + 14;
      void'(frames.pop_front());
    end
  endtask

  initial begin
    int sizes [4];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pop, zero length, extreme bytes, capacity too small
    send(CmdPop, 8'hFF, 12'hFFF, 13'h1FFF);
    send(CmdPush, 8'h00, 12'd0, 13'd0);
    drain();
    send(CmdPush, 8'h00, 12'd1, 13'd0);
    send(CmdPush, 8'hFF, 12'd2, 13'd0);
    send(CmdPush, 8'h5A, 12'd0, 13'd0);
    send(CmdPop, 8'h00, 12'd0, 13'd1);
    send(CmdPop, 8'h00, 12'd0, 13'd2);
    send(CmdPop, 8'h00, 12'd0, 13'd0);
    send(CmdPush, 8'h33, 12'd1, 13'd0);
    send(CmdPop, 8'h00, 12'd0, 13'd0);
    send(CmdPop, 8'h00, 12'd0, 13'd0);
    set_ring(13'd16);
    send(CmdPush, 8'h11, 12'd3, 13'd0);
    send(CmdPush, 8'h22, 12'd0, 13'd0);
    send(CmdPush, 8'h33, 12'd0, 13'd0);
    send(CmdPush, 8'h44, 12'd2, 13'd0);
    send(CmdPush, 8'h55, 12'd0, 13'd0);
    send(CmdPush, 8'h66, 12'd1, 13'd0);
    send(CmdPop, 8'h00, 12'd0, 13'd4096);
    send(CmdPop, 8'h00, 12'd0, 13'd0);
    set_ring(13'd0);
    send(CmdPush, 8'h77, 12'd2, 13'd0);
    set_ring(13'h1FFF);
    send(CmdPush, 8'h88, 12'hFFF, 13'd0);
    send(CmdPush, 8'h99, 12'd0, 13'd0);
    set_ring(13'd4096);

    // largest message that fits a small ring, then pop it whole
    set_ring(13'd64);
    repeat (50) push_byte(50);
    repeat (50) pop_byte(0);

    sizes = '{16, 4096, 0, 0};
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      if (ph == 2) set_ring(13'($urandom));
      else if (ph == 3) set_ring(13'($urandom_range(16, 600)));
      else set_ring(13'(sizes[ph]));
      for (int n = 0; n < 275; n++) begin
        if (n == 150 && ph == 1) drain();
        if ($urandom_range(99) < (frames.size() > 2 ? 40 : 60)) push_byte(0);
        else pop_byte(1);
      end
    end

    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== framed_message_ring_buffer.f =====
hdl/fmrb_pkg.sv
hdl/fmrb_ram.sv
hdl/fmrb_core.sv
hdl/framed_message_ring_buffer.sv
tb/fmrb_checker.sv
tb/framed_message_ring_buffer_tb.sv
